/* rtl/grouped_multi_queue_pool_unit_assert.svh */
// Assertion macros for the grouped multi-queue pool unit.
// Used by gmqp_back; no other dependencies.
`ifndef GROUPED_MULTI_QUEUE_POOL_UNIT_ASSERT_SVH
`define GROUPED_MULTI_QUEUE_POOL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define GMQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define GMQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GMQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/gmqp_pkg.sv */
// Shared types and constants of the grouped multi-queue pool unit.
// No dependencies.
package gmqp_pkg;
	localparam int NUM_GROUPS       = 16;
	localparam int POOL_ENTRIES_DEF = 256;
	localparam int HANDLE_BITS      = 32;

	localparam logic [1:0] KIND_PUT  = 2'd0;
	localparam logic [1:0] KIND_GET  = 2'd1;
	localparam logic [1:0] KIND_STEP = 2'd2;
	localparam logic [1:0] KIND_ALL  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ZERO  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  group;
		logic [31:0] handle;
		logic        zero;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] handle_out;
		logic [3:0]  group_out;
	} rsp_t;
endpackage

/* rtl/gmqp_front.sv */
// Front part: accepts items, classifies them and queues them as commands.
// Depends on gmqp_pkg.
module gmqp_front import gmqp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_kind,
	input  logic [3:0]  in_group,
	input  logic [31:0] in_handle,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);
	cmd_t       buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	logic [31:0] hm;

	assign hm = in_handle & (32'hFFFF_FFFF >> (32 - HANDLE_BITS));
	assign in_ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = buf_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= '{kind: in_kind, group: in_group, handle: hm, zero: (hm == 32'd0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* rtl/gmqp_back.sv */
// Back part: sequencer over the shared entry store and per-group queue state.
// Depends on gmqp_pkg and the assertion macro header.
`include "grouped_multi_queue_pool_unit_assert.svh"
module gmqp_back import gmqp_pkg::*; #(
	parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);
	localparam int EW = $clog2(POOL_ENTRIES);
	localparam int GW = $clog2(NUM_GROUPS);
	localparam int CW = EW + 1;

	typedef enum logic [7:0] {
		S_INIT = 8'b00000001,
		S_IDLE = 8'b00000010,
		S_DEC  = 8'b00000100,
		S_LINK = 8'b00001000,
		S_HIT  = 8'b00010000,
		S_EXEC = 8'b00100000,
		S_TAIL = 8'b01000000,
		S_OUT  = 8'b10000000
	} st_t;

	st_t st_q;
	logic [31:0] hmem [POOL_ENTRIES];
	logic [EW-1:0] lmem [POOL_ENTRIES];
	logic [EW-1:0] qhead_q [NUM_GROUPS];
	logic [EW-1:0] qtail_q [NUM_GROUPS];
	logic [CW-1:0] qlen_q [NUM_GROUPS];
	logic [EW-1:0] cur_q [NUM_GROUPS];
	logic [NUM_GROUPS-1:0] curv_q;
	logic [EW-1:0] fhead_q;
	logic [CW-1:0] fcnt_q;
	logic [GW-1:0] walk_q;
	logic [EW-1:0] init_q;
	cmd_t c_q;
	logic [GW-1:0] g_q;
	logic [EW-1:0] node_q;
	logic [31:0] hrd_q;
	logic [EW-1:0] lrd_q;
	logic [EW-1:0] hraddr, lraddr;
	logic hwen, lwen;
	logic [EW-1:0] lwaddr, lwdata;
	rsp_t res_q, rsp_q;
	logic rv_q;
	logic out_load;

	assign cmd_ready = (st_q == S_IDLE);
	assign out_load = (st_q == S_OUT) && (!rv_q || rsp_ready);
	assign rsp_valid = rv_q;
	assign rsp = rsp_q;

	always_comb begin
		hraddr = node_q;
		lraddr = node_q;
		if (st_q == S_DEC) begin
			case (c_q.kind)
				KIND_PUT: lraddr = fhead_q;
				KIND_GET: begin
					hraddr = qhead_q[g_q];
					lraddr = qhead_q[g_q];
				end
				default: begin
					hraddr = qhead_q[g_q];
					lraddr = cur_q[g_q];
				end
			endcase
		end else if (st_q == S_LINK) begin
			hraddr = lrd_q;
		end
	end

	always_comb begin
		hwen = (st_q == S_EXEC) && (c_q.kind == KIND_PUT);
		lwen = 1'b0;
		lwaddr = node_q;
		lwdata = node_q;
		case (st_q)
			S_INIT: begin
				lwen = 1'b1;
				lwaddr = init_q;
				lwdata = (init_q == EW'(POOL_ENTRIES - 1)) ? '0 : init_q + EW'(1);
			end
			S_EXEC: begin
				lwen = 1'b1;
				if (c_q.kind == KIND_PUT) begin
					if (qlen_q[g_q] != '0) lwaddr = qtail_q[g_q];
				end else begin
					lwdata = fhead_q;
				end
			end
			S_TAIL: lwen = 1'b1;
			default: lwen = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		hrd_q <= hmem[hraddr];
		lrd_q <= lmem[lraddr];
		if (hwen) hmem[node_q] <= c_q.handle;
		if (lwen) lmem[lwaddr] <= lwdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			rv_q <= out_load || (rv_q && !rsp_ready);
			if (out_load) rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_INIT;
			init_q <= '0;
			fhead_q <= '0;
			fcnt_q <= CW'(POOL_ENTRIES);
			walk_q <= '0;
			curv_q <= '0;
			c_q <= '0;
			g_q <= '0;
			node_q <= '0;
			res_q <= '0;
			for (int i = 0; i < NUM_GROUPS; i++) begin
				qhead_q[i] <= '0;
				qtail_q[i] <= '0;
				qlen_q[i] <= '0;
				cur_q[i] <= '0;
			end
		end else begin
			case (st_q)
				S_INIT: begin
					if (init_q == EW'(POOL_ENTRIES - 1)) st_q <= S_IDLE;
					else init_q <= init_q + EW'(1);
				end
				S_IDLE: begin
					if (cmd_valid) begin
						c_q <= cmd;
						g_q <= (cmd.kind == KIND_ALL) ? walk_q : GW'(cmd.group);
						st_q <= S_DEC;
					end
				end
				S_DEC: begin
					case (c_q.kind)
						KIND_PUT: begin
							node_q <= fhead_q;
							if (c_q.zero) begin
								res_q <= '{status: ST_ZERO, handle_out: 32'd0,
									group_out: 4'(g_q)};
								st_q <= S_OUT;
							end else if (fcnt_q == '0) begin
								res_q <= '{status: ST_FULL, handle_out: 32'd0,
									group_out: 4'(g_q)};
								st_q <= S_OUT;
							end else begin
								st_q <= S_EXEC;
							end
						end
						KIND_GET: begin
							node_q <= qhead_q[g_q];
							if (qlen_q[g_q] == '0) begin
								res_q <= '{status: ST_EMPTY, handle_out: 32'd0,
									group_out: 4'(g_q)};
								st_q <= S_OUT;
							end else begin
								st_q <= S_EXEC;
							end
						end
						default: begin
							if (!curv_q[g_q] && qlen_q[g_q] != '0) begin
								node_q <= qhead_q[g_q];
								st_q <= S_HIT;
							end else if (curv_q[g_q] && cur_q[g_q] != qtail_q[g_q]) begin
								st_q <= S_LINK;
							end else begin
								curv_q[g_q] <= 1'b0;
								if (c_q.kind == KIND_STEP) begin
									res_q <= '{status: ST_EMPTY, handle_out: 32'd0,
										group_out: 4'(g_q)};
									st_q <= S_OUT;
								end else if (g_q == GW'(NUM_GROUPS - 1)) begin
									walk_q <= '0;
									res_q <= '{status: ST_EMPTY, handle_out: 32'd0,
										group_out: 4'd0};
									st_q <= S_OUT;
								end else begin
									g_q <= g_q + GW'(1);
								end
							end
						end
					endcase
				end
				S_LINK: begin
					node_q <= lrd_q;
					st_q <= S_HIT;
				end
				S_HIT: begin
					cur_q[g_q] <= node_q;
					curv_q[g_q] <= 1'b1;
					if (c_q.kind == KIND_ALL) walk_q <= g_q;
					res_q <= '{status: ST_OK, handle_out: hrd_q, group_out: 4'(g_q)};
					st_q <= S_OUT;
				end
				S_EXEC: begin
					if (c_q.kind == KIND_PUT) begin
						fhead_q <= lrd_q;
						fcnt_q <= fcnt_q - CW'(1);
						qtail_q[g_q] <= node_q;
						qlen_q[g_q] <= qlen_q[g_q] + CW'(1);
						res_q <= '{status: ST_OK, handle_out: 32'd0, group_out: 4'(g_q)};
						if (qlen_q[g_q] == '0) begin
							qhead_q[g_q] <= node_q;
							st_q <= S_OUT;
						end else begin
							st_q <= S_TAIL;
						end
					end else begin
						res_q <= '{status: ST_OK, handle_out: hrd_q, group_out: 4'(g_q)};
						qhead_q[g_q] <= lrd_q;
						qlen_q[g_q] <= qlen_q[g_q] - CW'(1);
						if (curv_q[g_q] && cur_q[g_q] == node_q) begin
							curv_q[g_q] <= 1'b0;
							cur_q[g_q] <= '0;
						end
						fhead_q <= node_q;
						fcnt_q <= fcnt_q + CW'(1);
						st_q <= S_OUT;
					end
				end
				S_TAIL: st_q <= S_OUT;
				S_OUT: begin
					if (out_load) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`GMQ_ASSERT_NXT(a_rsp_hold, clk, arst_n, rv_q && !rsp_ready, rv_q && $stable(rsp_q))
	`GMQ_ASSERT_IMP(a_fcnt, clk, arst_n, 1'b1, fcnt_q <= CW'(POOL_ENTRIES))
	`GMQ_ASSERT_IMP(a_put_room, clk, arst_n, hwen, fcnt_q != '0)
endmodule

/* rtl/grouped_multi_queue_pool_unit.sv */
// Top level of the grouped multi-queue pool unit: per-group handle FIFOs
// sharing one linked entry store. Depends on gmqp_pkg, gmqp_front, gmqp_back.
//
// Input stream s_axis: tdata = {handle[35:4], group[3:0]}, tuser = kind.
// Output stream m_axis: tdata = {group_out[35:32], handle_out[31:0]}, tuser = status.
// Each item yields exactly one result item, in order.
// Path from input accept to m_axis_tvalid, through the sequencer states:
// a rejected put, an empty get or a group step with no next entry goes
// from decode straight to the output state; a put to an empty group, a get
// or a group step from the head also passes an execute or hit state; a put
// to a non-empty group adds a tail write, a group step past the head a link
// read. An all-groups step decodes each group it examines, then ends the walk
// or takes the head-hit or past-head path. The back part works one item at
// a time while a two-entry command queue keeps the input side taking items.
// After reset the back part chains the free list over all POOL_ENTRIES
// entries and takes no item meanwhile; the command queue still takes two items.
// A stalled receiver holds the result register; the back part finishes one
// more item and waits, the command queue fills and s_axis_tready drops.
module grouped_multi_queue_pool_unit import gmqp_pkg::*; #(
	parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // group[3:0], handle[35:4], zero fill
	input  logic [1:0]  s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // handle_out[31:0], group_out[35:32], zero fill
	output logic [1:0]  m_axis_tuser   // status
);
	logic cmd_valid, cmd_ready;
	cmd_t cmd;
	rsp_t rsp;

	gmqp_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_kind(s_axis_tuser), .in_group(s_axis_tdata[3:0]),
		.in_handle(s_axis_tdata[35:4]),
		.cmd_valid, .cmd_ready, .cmd
	);

	gmqp_back #(.POOL_ENTRIES(POOL_ENTRIES)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready), .rsp
	);

	assign m_axis_tdata = {4'd0, rsp.group_out, rsp.handle_out};
	assign m_axis_tuser = rsp.status;
endmodule

/* dv/grouped_multi_queue_pool_unit_checker.sv */
// Checker for the grouped multi-queue pool unit: watches both streams, predicts
// each result from a behavioral copy of the queues and compares. Depends on gmqp_pkg.
module grouped_multi_queue_pool_unit_checker import gmqp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	output int          fail_count,
	output int          pending
);
	localparam int NG = 16;
	localparam int NE = 256;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] handle_out;
		logic [3:0]  group_out;
	} result_t;

	logic [31:0] pool_handle[NE];
	logic [7:0]  pool_link[NE];
	logic [7:0]  free_head;
	int          free_count;
	logic [7:0]  q_head[NG];
	logic [7:0]  q_tail[NG];
	int          q_len[NG];
	logic        cur_valid[NG];
	logic [7:0]  cur_entry[NG];
	int          walk_pos;
	result_t     expected_results[$];

	function automatic bit step_cursor(input int g, output logic [7:0] node);
		if (!cur_valid[g]) begin
			if (q_len[g] == 0) return 0;
			node = q_head[g];
		end else begin
			if (cur_entry[g] == q_tail[g]) begin
				cur_valid[g] = 0;
				return 0;
			end
			node = pool_link[cur_entry[g]];
		end
		cur_entry[g] = node;
		cur_valid[g] = 1;
		return 1;
	endfunction

	function automatic result_t apply_item(input logic [1:0] kind, input logic [3:0] g,
		input logic [31:0] h);
		result_t r;
		logic [7:0] node;
		int w;
		bit found;
		r = '{status: ST_OK, handle_out: '0, group_out: g};
		case (kind)
			KIND_PUT: begin
				if (h == 0) r.status = ST_ZERO;
				else if (free_count == 0) r.status = ST_FULL;
				else begin
					node = free_head;
					free_head = pool_link[node];
					free_count--;
					pool_handle[node] = h;
					pool_link[node] = node;
					if (q_len[g] == 0) q_head[g] = node;
					else pool_link[q_tail[g]] = node;
					q_tail[g] = node;
					q_len[g]++;
				end
			end
			KIND_GET: begin
				if (q_len[g] == 0) r.status = ST_EMPTY;
				else begin
					node = q_head[g];
					r.handle_out = pool_handle[node];
					q_head[g] = pool_link[node];
					q_len[g]--;
					if (cur_valid[g] && cur_entry[g] == node) begin
						cur_valid[g] = 0;
						cur_entry[g] = 0;
					end
					pool_link[node] = free_head;
					free_head = node;
					free_count++;
				end
			end
			KIND_STEP: begin
				if (step_cursor(g, node)) r.handle_out = pool_handle[node];
				else r.status = ST_EMPTY;
			end
			default: begin
				found = 0;
				for (w = walk_pos; w < NG; w++) begin
					if (step_cursor(w, node)) begin
						found = 1;
						break;
					end
				end
				if (found) begin
					walk_pos = w;
					r.handle_out = pool_handle[node];
					r.group_out = w[3:0];
				end else begin
					walk_pos = 0;
					r.status = ST_EMPTY;
					r.group_out = '0;
				end
			end
		endcase
		return r;
	endfunction

	result_t got, want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NE; i++) pool_link[i] = 8'(i + 1);
			for (int i = 0; i < NG; i++) begin
				q_head[i] = 0;
				q_tail[i] = 0;
				q_len[i] = 0;
				cur_valid[i] = 0;
				cur_entry[i] = 0;
			end
			free_head = 0;
			free_count = NE;
			walk_pos = 0;
			fail_count = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(apply_item(s_axis_tuser, s_axis_tdata[3:0],
					s_axis_tdata[35:4]));
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{status: m_axis_tuser, handle_out: m_axis_tdata[31:0],
					group_out: m_axis_tdata[35:32]};
				if (expected_results.size() == 0) begin
					$error("unexpected result item: status %0d handle_out %h group_out %0d",
						got.status, got.handle_out, got.group_out);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.status != want.status) begin
						$error("status: expected %0d actual %0d", want.status, got.status);
						fail_count++;
					end
					if (got.handle_out != want.handle_out) begin
						$error("handle_out: expected %h actual %h", want.handle_out,
							got.handle_out);
						fail_count++;
					end
					if (got.group_out != want.group_out) begin
						$error("group_out: expected %0d actual %0d", want.group_out,
							got.group_out);
						fail_count++;
					end
				end
			end
			pending = expected_results.size();
		end
	end
endmodule

/* dv/grouped_multi_queue_pool_unit_test.sv */
// Testbench top for the grouped multi-queue pool unit: drives put, get and
// step items under varied idling and gives the verdict. Depends on gmqp_pkg,
// the unit and grouped_multi_queue_pool_unit_checker.
module grouped_multi_queue_pool_unit_test import gmqp_pkg::*; ();
	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = KIND_PUT;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	int          fail_count;
	int          pending;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic [1:0]  kind_list[$];
	logic [3:0]  group_list[$];
	logic [31:0] handle_list[$];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	grouped_multi_queue_pool_unit i_dut (.*);

	grouped_multi_queue_pool_unit_checker i_checker (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1500000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic add_item(input logic [1:0] k, input logic [3:0] g, input logic [31:0] h);
		kind_list.push_back(k);
		group_list.push_back(g);
		handle_list.push_back(h);
	endtask

	function automatic logic [31:0] rand_handle();
		case ($urandom_range(5))
			0: return 32'hFFFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'd1;
			3: return 32'hAAAA_5555;
			default: return $urandom() | 32'd1;
		endcase
	endfunction

	task automatic send_all();
		while (kind_list.size() > 0) begin
			if ($urandom_range(99) < send_idle_pct) begin
				s_axis_tvalid <= 0;
				@(posedge clk);
			end else begin
				s_axis_tvalid <= 1;
				s_axis_tuser <= kind_list.pop_front();
				s_axis_tdata <= {4'b0, handle_list.pop_front(), group_list.pop_front()};
				@(posedge clk);
				while (!s_axis_tready) @(posedge clk);
			end
		end
		s_axis_tvalid <= 0;
	endtask

	task automatic random_phase(input int n, input int idle, input int stall);
		int r;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 40)
				add_item(KIND_PUT, 4'($urandom_range(15)),
					($urandom_range(19) == 0) ? 32'd0 : rand_handle());
			else if (r < 65) add_item(KIND_GET, 4'($urandom_range(15)), 32'd0);
			else if (r < 83) add_item(KIND_STEP, 4'($urandom_range(15)), $urandom());
			else add_item(KIND_ALL, 4'($urandom_range(15)), $urandom());
		end
		send_all();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		add_item(KIND_GET, 4'd0, 0);
		add_item(KIND_STEP, 4'd15, 0);
		add_item(KIND_ALL, 4'd0, 0);
		add_item(KIND_PUT, 4'd3, 32'd0);
		add_item(KIND_PUT, 4'd0, 32'hFFFF_FFFF);
		add_item(KIND_PUT, 4'd15, 32'd1);
		add_item(KIND_PUT, 4'd15, 32'h8000_0000);
		add_item(KIND_STEP, 4'd15, 0);
		add_item(KIND_GET, 4'd15, 0);
		add_item(KIND_STEP, 4'd15, 0);
		add_item(KIND_STEP, 4'd15, 0);
		add_item(KIND_ALL, 4'd7, 0);
		add_item(KIND_ALL, 4'd0, 0);
		add_item(KIND_ALL, 4'd0, 0);
		add_item(KIND_GET, 4'd0, 0);
		add_item(KIND_GET, 4'd15, 0);
		send_all();
		// fill the pool past full, then drain
		for (int i = 0; i < 258; i++) add_item(KIND_PUT, i[3:0], rand_handle());
		add_item(KIND_ALL, 4'd0, 0);
		add_item(KIND_STEP, 4'd5, 0);
		for (int i = 0; i < 256; i++) add_item(KIND_GET, i[3:0], 0);
		send_all();
		random_phase(300, 0, 0);
		random_phase(300, 69, 0);
		random_phase(300, 0, 69);
		random_phase(300, 29, 29);
		random_phase(20, 0, 0);
		recv_stall_pct = 0;
		while (pending > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule
